>>> sv/square_matrix_rotate_90_cw_macros.svh
// assertion macros used by the matrix rotate controller
`ifndef SQUARE_MATRIX_ROTATE_90_CW_MACROS_SVH
`define SQUARE_MATRIX_ROTATE_90_CW_MACROS_SVH

// same-cycle implication, checked outside reset
`define SMR90_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smr90 check failed");

// next-cycle implication, checked outside reset
`define SMR90_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smr90 check failed");

`endif

>>> sv/smr90_pkg.sv
// shared types, constants and helpers for the matrix rotate block
package smr90_pkg;

    // parameter defaults
    localparam int unsigned DEF_MAX_SIDE     = 64;
    localparam int unsigned DEF_ELEMENT_BITS = 32;

    // fixed field widths
    localparam int unsigned OUT_BITS      = 32;
    localparam int unsigned SIZE_BITS     = 7;
    localparam int unsigned APB_DATA_BITS = 32;
    localparam int unsigned APB_ADDR_BITS = 3;

    // register reset value and register index (paddr bit 2)
    localparam logic [SIZE_BITS-1:0] SIZE_RESET   = 7'd64;
    localparam logic                 REG_IDX_SIZE = 1'b0;

    // item operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    // output register state
    typedef enum logic [0:0] {
        ST_EMPTY,
        ST_FULL
    } t_ctl_state;

    // memory commands from controller to datapath
    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic rd_last;
    } t_mem_cmd;

    // side length in use: zero acts as one, large values clamp to the maximum
    function automatic int unsigned side_len(input logic [SIZE_BITS-1:0] size,
                                             input int unsigned max_side);
        int unsigned s;
        s = int'(size);
        if (s == 0) begin
            return 1;
        end else if (s > max_side) begin
            return max_side;
        end
        return s;
    endfunction

endpackage

>>> sv/smr90_ctrl.sv
// controller: handshake, output register state and load/read address walks
`include "square_matrix_rotate_90_cw_macros.svh"

module smr90_ctrl #(
    parameter int unsigned MAX_SIDE = smr90_pkg::DEF_MAX_SIDE,
    localparam int unsigned CW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1,
    localparam int unsigned NW = $clog2(MAX_SIDE + 1),
    localparam int unsigned AW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE * MAX_SIDE) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [NW-1:0]       i_side,
    input  logic                i_clear,
    input  logic                i_in_valid,
    input  logic                i_op,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output smr90_pkg::t_mem_cmd o_cmd,
    output logic [AW-1:0]       o_wr_addr,
    output logic [AW-1:0]       o_rd_addr
);

    smr90_pkg::t_ctl_state r_state, n_state;
    logic [CW-1:0] r_ld_row, n_ld_row, r_ld_col, n_ld_col;
    logic [CW-1:0] r_rd_row, n_rd_row, r_rd_col, n_rd_col;
    logic          accept;
    logic          out_taken;
    logic          ld_col_end, ld_row_end, rd_col_end, rd_row_end;
    logic [CW-1:0] src_row;

    // end-of-row and end-of-frame detection
    always_comb begin
        ld_col_end = (NW'(r_ld_col) + NW'(1)) >= i_side;
        ld_row_end = (NW'(r_ld_row) + NW'(1)) >= i_side;
        rd_col_end = (NW'(r_rd_col) + NW'(1)) >= i_side;
        rd_row_end = (NW'(r_rd_row) + NW'(1)) >= i_side;
        // output (i,j) comes from input (n-1-j, i)
        src_row    = CW'(i_side - NW'(1) - NW'(r_rd_col));
    end

    // addresses, row * MAX_SIDE + col
    assign o_wr_addr = AW'(r_ld_row) * AW'(MAX_SIDE) + AW'(r_ld_col);
    assign o_rd_addr = AW'(src_row) * AW'(MAX_SIDE) + AW'(r_rd_row);

    // handshake and next state
    always_comb begin
        out_taken   = (r_state == smr90_pkg::ST_FULL) && !i_out_stall;
        // loads go on while a result waits; a read waits for the output slot
        o_in_stall  = (i_op == smr90_pkg::OP_READ) && (r_state == smr90_pkg::ST_FULL)
                      && i_out_stall;
        accept      = i_in_valid && !o_in_stall;
        o_out_valid = (r_state == smr90_pkg::ST_FULL);

        o_cmd.wr_en   = accept && (i_op == smr90_pkg::OP_LOAD);
        o_cmd.rd_en   = accept && (i_op == smr90_pkg::OP_READ);
        o_cmd.rd_last = rd_row_end && rd_col_end;

        n_state = r_state;
        case (r_state)
            smr90_pkg::ST_EMPTY: begin
                if (o_cmd.rd_en) begin
                    n_state = smr90_pkg::ST_FULL;
                end
            end
            smr90_pkg::ST_FULL: begin
                if (out_taken && !o_cmd.rd_en) begin
                    n_state = smr90_pkg::ST_EMPTY;
                end
            end
            default: begin
                n_state = smr90_pkg::ST_EMPTY;
            end
        endcase
    end

    // next positions of the load and read walks
    always_comb begin
        n_ld_row = r_ld_row;
        n_ld_col = r_ld_col;
        n_rd_row = r_rd_row;
        n_rd_col = r_rd_col;
        if (o_cmd.wr_en) begin
            if (ld_col_end) begin
                n_ld_col = '0;
                n_ld_row = ld_row_end ? '0 : r_ld_row + CW'(1);
            end else begin
                n_ld_col = r_ld_col + CW'(1);
            end
        end
        if (o_cmd.rd_en) begin
            if (rd_col_end) begin
                n_rd_col = '0;
                n_rd_row = rd_row_end ? '0 : r_rd_row + CW'(1);
            end else begin
                n_rd_col = r_rd_col + CW'(1);
            end
        end
        // a size write restarts both walks
        if (i_clear) begin
            n_ld_row = '0;
            n_ld_col = '0;
            n_rd_row = '0;
            n_rd_col = '0;
        end
    end

    // state and counter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= smr90_pkg::ST_EMPTY;
            r_ld_row <= '0;
            r_ld_col <= '0;
            r_rd_row <= '0;
            r_rd_col <= '0;
        end else begin
            r_state  <= n_state;
            r_ld_row <= n_ld_row;
            r_ld_col <= n_ld_col;
            r_rd_row <= n_rd_row;
            r_rd_col <= n_rd_col;
        end
    end

    // checks
    `SMR90_ASSERT_NEXT(a_read_fills_output, i_clk, i_rst_n, o_cmd.rd_en, o_out_valid)
    `SMR90_ASSERT_NOW(a_load_pos_in_frame, i_clk, i_rst_n, 1'b1,
        (NW'(r_ld_row) < i_side) && (NW'(r_ld_col) < i_side))
    `SMR90_ASSERT_NOW(a_read_pos_in_frame, i_clk, i_rst_n, 1'b1,
        (NW'(r_rd_row) < i_side) && (NW'(r_rd_col) < i_side))
    `SMR90_ASSERT_NEXT(a_last_wraps_walk, i_clk, i_rst_n, o_cmd.rd_en && o_cmd.rd_last,
        (r_rd_row == '0) && (r_rd_col == '0))

endmodule

>>> sv/smr90_dpath.sv
// datapath: frame store memory and registered result
module smr90_dpath #(
    parameter int unsigned MAX_SIDE     = smr90_pkg::DEF_MAX_SIDE,
    parameter int unsigned ELEMENT_BITS = smr90_pkg::DEF_ELEMENT_BITS,
    localparam int unsigned AW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE * MAX_SIDE) : 1,
    localparam int unsigned DEPTH = MAX_SIDE * MAX_SIDE
) (
    input  logic                                    i_clk,
    input  smr90_pkg::t_mem_cmd                     i_cmd,
    input  logic [AW-1:0]                           i_wr_addr,
    input  logic [AW-1:0]                           i_rd_addr,
    input  logic signed [smr90_pkg::OUT_BITS-1:0]   i_element_value,
    output logic signed [smr90_pkg::OUT_BITS-1:0]   o_rotated_value,
    output logic                                    o_frame_last
);

    localparam int unsigned OW = smr90_pkg::OUT_BITS;

    logic [ELEMENT_BITS-1:0] r_mem [DEPTH];
    logic [ELEMENT_BITS-1:0] r_rd_data;
    logic                    r_rd_last;
    logic [ELEMENT_BITS-1:0] wr_data;

    // fit the element to the store width, and the stored word to the output
    generate
        if (ELEMENT_BITS <= smr90_pkg::OUT_BITS) begin : g_narrow
            assign wr_data         = i_element_value[ELEMENT_BITS-1:0];
            assign o_rotated_value = OW'(r_rd_data);
        end else begin : g_wide
            assign wr_data         = {{(ELEMENT_BITS - smr90_pkg::OUT_BITS){1'b0}},
                                      i_element_value};
            assign o_rotated_value = r_rd_data[smr90_pkg::OUT_BITS-1:0];
        end
    endgenerate

    // frame store write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_wr_addr] <= wr_data;
        end
    end

    // frame store read port, held until the next read item
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_last <= i_cmd.rd_last;
        end
    end

    assign o_frame_last = r_rd_last;

endmodule

>>> sv/square_matrix_rotate_90_cw.sv
// top level: 90 degree clockwise matrix rotation through a frame store
//
// Input channel (i_in_valid / o_in_stall): i_op selects a load (element
// i_element_value is written at the next row-major position) or a read
// (the next element of the rotated matrix is fetched). Output channel
// (o_out_valid / i_out_stall) carries one result per read: o_rotated_value
// and o_frame_last, which marks the final element of the rotated frame.
// Loads give no result. Both walks wrap after n*n items; read a frame only
// after it has been fully loaded.
// An accepted read's result is registered before it is shown.
// Throughput: one item per cycle, loads or reads, unless a read waits on a stall;
// the single output register (the registered read port of the frame store)
// limits reads to one per cycle. When the receiver stalls, the result is held;
// loads are still taken, and a read waits until the held result leaves.
// matrix_size (APB, address 0) sets n; a write restarts both walks and must
// be made while the block is idle. Reset clears the walks and the output
// register state and sets n to 64; the frame store keeps no reset value.
module square_matrix_rotate_90_cw #(
    parameter int unsigned MAX_SIDE     = smr90_pkg::DEF_MAX_SIDE,
    parameter int unsigned ELEMENT_BITS = smr90_pkg::DEF_ELEMENT_BITS
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    // configuration port
    input  logic                                        psel,
    input  logic                                        penable,
    input  logic                                        pwrite,
    input  logic [smr90_pkg::APB_ADDR_BITS-1:0]         paddr,
    input  logic [smr90_pkg::APB_DATA_BITS-1:0]         pwdata,
    output logic [smr90_pkg::APB_DATA_BITS-1:0]         prdata,
    output logic                                        pready,
    // input items
    input  logic                                        i_in_valid,
    output logic                                        o_in_stall,
    input  logic                                        i_op,
    input  logic signed [smr90_pkg::OUT_BITS-1:0]       i_element_value,
    // result items
    output logic                                        o_out_valid,
    input  logic                                        i_out_stall,
    output logic signed [smr90_pkg::OUT_BITS-1:0]       o_rotated_value,
    output logic                                        o_frame_last
);

    localparam int unsigned NW = $clog2(MAX_SIDE + 1);
    localparam int unsigned AW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE * MAX_SIDE) : 1;

    logic [smr90_pkg::SIZE_BITS-1:0] r_matrix_size;
    logic                            size_wr;
    logic [NW-1:0]                   side;
    smr90_pkg::t_mem_cmd             cmd;
    logic [AW-1:0]                   wr_addr;
    logic [AW-1:0]                   rd_addr;

    // register access
    assign pready  = 1'b1;
    assign size_wr = psel && penable && pwrite && pready
                     && (paddr[2] == smr90_pkg::REG_IDX_SIZE);
    assign prdata  = (paddr[2] == smr90_pkg::REG_IDX_SIZE)
                     ? {{(smr90_pkg::APB_DATA_BITS - smr90_pkg::SIZE_BITS){1'b0}}, r_matrix_size}
                     : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matrix_size <= smr90_pkg::SIZE_RESET;
        end else if (size_wr) begin
            r_matrix_size <= pwdata[smr90_pkg::SIZE_BITS-1:0];
        end
    end

    // side length in use
    assign side = NW'(smr90_pkg::side_len(r_matrix_size, MAX_SIDE));

    smr90_ctrl #(
        .MAX_SIDE (MAX_SIDE)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_side      (side),
        .i_clear     (size_wr),
        .i_in_valid  (i_in_valid),
        .i_op        (i_op),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .o_wr_addr   (wr_addr),
        .o_rd_addr   (rd_addr)
    );

    smr90_dpath #(
        .MAX_SIDE     (MAX_SIDE),
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_cmd           (cmd),
        .i_wr_addr       (wr_addr),
        .i_rd_addr       (rd_addr),
        .i_element_value (i_element_value),
        .o_rotated_value (o_rotated_value),
        .o_frame_last    (o_frame_last)
    );

endmodule
